// ===== rtl/core/fcr_pkg.sv =====
package fcr_pkg;

	localparam int ROWS_IN_PAGE = 8;
	localparam int COORD_W      = 12;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic PEN_CLEAR = 1'b0;
	localparam logic PEN_SET   = 1'b1;

endpackage

// ===== rtl/core/fcr_ram.sv =====
module fcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/core/filled_circle_rasterizer.sv =====
// A read passes through S_READ, where the memory is read, and S_DONE, where the result is registered.
// A draw reads and writes back the byte of each covered pixel (S_PIX_RD, then S_PIX_WR),
// checks the four spans of each circle step in S_SPAN, and takes the next step in S_WALK.
// One item is in work at a time; the single port of the frame buffer memory bounds the rate.
// After reset all FB_WIDTH*FB_HEIGHT/8 bytes of the frame buffer (1024 by default) are cleared,
// during which no item is accepted.
module filled_circle_rasterizer
	import fcr_pkg::*;
#(
	parameter int FB_WIDTH  = 128,
	parameter int FB_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// ctr_col[6:0], ctr_row[12:7], radius[19:13], color[20], read_address[30:21], zero[31]
	input  logic [31:0] s_tdata,
	// op[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0]
	output logic [7:0]  m_tdata,
	// was_read[0]
	output logic        m_tuser
);

	localparam int FB_BYTES = FB_WIDTH * FB_HEIGHT / ROWS_IN_PAGE;
	localparam int AW       = $clog2(FB_BYTES);
	localparam int SAW      = AW + 1;
	localparam int CNT_W    = $clog2(FB_WIDTH);

	localparam coord_t W_LAST = COORD_W'(FB_WIDTH - 1);
	localparam coord_t H_LIM  = COORD_W'(FB_HEIGHT);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SPAN,
		S_PIX_RD,
		S_PIX_WR,
		S_WALK,
		S_DONE
	} state_t;

	state_t state_q;

	logic [6:0] ctr_col;
	logic [5:0] ctr_row;
	logic [6:0] radius;
	logic       color;
	logic [9:0] read_address;

	assign ctr_col      = s_tdata[6:0];
	assign ctr_row      = s_tdata[12:7];
	assign radius       = s_tdata[19:13];
	assign color        = s_tdata[20];
	assign read_address = s_tdata[30:21];

	coord_t               cx_q;
	coord_t               cy_q;
	coord_t               x_q;
	coord_t               y_q;
	coord_t               delta_q;
	logic                 color_q;
	logic                 is_read_q;
	logic                 oob_q;
	logic [1:0]           k_q;
	logic [SAW-1:0]       addr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [2:0]           bit_q;
	logic [AW-1:0]        clr_addr_q;
	logic                 m_tvalid_q;
	logic [7:0]           m_tdata_q;
	logic                 m_tuser_q;

	logic                 ram_en;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [7:0]           ram_wdata;
	logic [7:0]           ram_rdata;

	coord_t               row_c;
	coord_t               hw_c;
	coord_t               left_c;
	coord_t               right_c;
	coord_t               lc_c;
	coord_t               rc_c;
	logic                 span_ok;
	logic [SAW-1:0]       span_base;
	coord_t               sum_c;
	logic signed [COORD_W:0] err_c;
	logic                 out_free;
	logic [7:0]           pix_mask;

	fcr_ram #(
		.WIDTH(8),
		.DEPTH(FB_BYTES)
	) u_fb (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign pix_mask = 8'(1) << bit_q;

	always_comb begin
		unique case (k_q)
			2'd0: row_c = cy_q - y_q;
			2'd1: row_c = cy_q + y_q;
			2'd2: row_c = cy_q - x_q;
			default: row_c = cy_q + x_q;
		endcase
		hw_c    = k_q[1] ? y_q : x_q;
		left_c  = cx_q - hw_c;
		right_c = cx_q + hw_c;
		lc_c    = left_c[COORD_W-1] ? '0 : left_c;
		rc_c    = (right_c > W_LAST) ? W_LAST : right_c;
		span_ok = !row_c[COORD_W-1] && (row_c < H_LIM) && (lc_c <= rc_c);
		span_base = SAW'(SAW'(row_c[COORD_W-2:3]) * SAW'(FB_WIDTH))
			+ SAW'(lc_c[COORD_W-2:0]);
		sum_c = delta_q + y_q;
		err_c = $signed({sum_c[COORD_W-1], sum_c} <<< 1) - $signed((COORD_W + 1)'(1));
	end

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = addr_q[AW-1:0];
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_addr_q;
			end
			S_READ, S_PIX_RD: begin
				ram_en = 1'b1;
			end
			S_PIX_WR: begin
				if (addr_q < SAW'(FB_BYTES)) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_wdata = (color_q == PEN_SET) ? (ram_rdata | pix_mask)
						: (ram_rdata & ~pix_mask);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			m_tvalid_q <= 1'b0;
			k_q        <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(FB_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						is_read_q <= (s_tuser == OP_READ);
						oob_q     <= (32'(read_address) >= FB_BYTES);
						addr_q    <= SAW'(read_address);
						cx_q      <= coord_t'({{(COORD_W - 7){1'b0}}, ctr_col});
						cy_q      <= coord_t'({{(COORD_W - 6){1'b0}}, ctr_row});
						x_q       <= '0;
						y_q       <= coord_t'({{(COORD_W - 7){1'b0}}, radius});
						delta_q   <= coord_t'(1) - coord_t'({{(COORD_W - 8){1'b0}}, radius, 1'b0});
						color_q   <= color;
						k_q       <= '0;
						state_q   <= (s_tuser == OP_READ) ? S_READ : S_SPAN;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_SPAN: begin
					if (k_q == 2'd0 && y_q < x_q) begin
						state_q <= S_DONE;
					end else if (span_ok) begin
						addr_q  <= span_base;
						cnt_q   <= CNT_W'(rc_c - lc_c);
						bit_q   <= row_c[2:0];
						state_q <= S_PIX_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? S_WALK : S_SPAN;
					end
				end
				S_PIX_RD: begin
					state_q <= S_PIX_WR;
				end
				S_PIX_WR: begin
					if (cnt_q == '0) begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? S_WALK : S_SPAN;
					end else begin
						addr_q  <= addr_q + 1'b1;
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_PIX_RD;
					end
				end
				S_WALK: begin
					priority if (delta_q[COORD_W-1] && (err_c[COORD_W] || err_c == '0)) begin
						x_q     <= x_q + coord_t'(1);
						delta_q <= delta_q + (x_q <<< 1) + coord_t'(3);
					end else if (!delta_q[COORD_W-1] && delta_q != '0
						&& !err_c[COORD_W] && err_c != '0) begin
						y_q     <= y_q - coord_t'(1);
						delta_q <= delta_q - (y_q <<< 1) + coord_t'(1);
					end else begin
						x_q     <= x_q + coord_t'(1);
						y_q     <= y_q - coord_t'(1);
						delta_q <= delta_q + ((x_q - y_q) <<< 1) + coord_t'(4);
					end
					state_q <= S_SPAN;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= is_read_q;
						m_tdata_q  <= (is_read_q && !oob_q) ? ram_rdata : '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/fcr_checker.sv =====
module fcr_checker
	import fcr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser
);

	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one item is in work at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in work");

	// A read item keeps the block busy through its S_READ and S_DONE states.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_READ |=> !s_tready ##1 !s_tready)
		else $error("read item finished too early");

	// A draw answers with a zero byte.
	a_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 8'd0)
		else $error("draw result carries data");

endmodule

bind filled_circle_rasterizer fcr_checker u_fcr_checker (.*);

// ===== tb/sv/filled_circle_rasterizer_tb.sv =====
`timescale 1ns / 100ps

module filled_circle_rasterizer_tb;
	import fcr_pkg::*;

	localparam int FB_W = 128;
	localparam int FB_H = 64;
	localparam int FB_BYTES = FB_W * FB_H / ROWS_IN_PAGE;
	localparam int RANDOM_ITEMS = 266;
	localparam int CYCLE_LIMIT = 20000000;

	typedef struct packed {
		logic [7:0] read_data;
		logic       was_read;
	} fb_result_t;

	class circle_scoreboard;
		logic [7:0]  frame [FB_BYTES];
		logic [7:0]  walk_x;
		logic [7:0]  walk_y;
		logic [9:0]  walk_delta;
		fb_result_t  awaited [$];
		int          mismatches;
		int          checked;
		int          nonzero_reads;

		function new();
			foreach (frame[i])
				frame[i] = 8'h00;
			walk_x = '0;
			walk_y = '0;
			walk_delta = '0;
			mismatches = 0;
			checked = 0;
			nonzero_reads = 0;
		endfunction

		function void fill_row(int left, int right, int row, logic color);
			int addr;
			logic [7:0] bit_sel;
			if (row < 0 || row >= FB_H)
				return;
			bit_sel = 8'(1 << (row % ROWS_IN_PAGE));
			for (int c = left; c <= right; c++) begin
				if (c < 0 || c >= FB_W)
					continue;
				addr = (row / ROWS_IN_PAGE) * FB_W + c;
				if (color == PEN_SET)
					frame[addr] = frame[addr] | bit_sel;
				else
					frame[addr] = frame[addr] & ~bit_sel;
			end
		endfunction

		function void note_item(logic op, logic [31:0] data);
			fb_result_t res;
			int addr, cx, cy, x, y, delta, err;
			logic color;
			if (op == OP_READ) begin
				addr = int'(data[30:21]);
				res.read_data = (addr < FB_BYTES) ? frame[addr] : 8'h00;
				res.was_read = 1'b1;
			end else begin
				cx = int'(data[6:0]);
				cy = int'(data[12:7]);
				y = int'(data[19:13]);
				color = data[20];
				x = 0;
				delta = 1 - 2 * y;
				while (y >= x) begin
					fill_row(cx - x, cx + x, cy - y, color);
					fill_row(cx - x, cx + x, cy + y, color);
					fill_row(cx - y, cx + y, cy - x, color);
					fill_row(cx - y, cx + y, cy + x, color);
					err = 2 * (delta + y) - 1;
					if (delta < 0 && err <= 0) begin
						x++;
						delta += 2 * x + 1;
					end else if (delta > 0 && err > 0) begin
						y--;
						delta -= 2 * y + 1;
					end else begin
						x++;
						y--;
						delta += 2 * (x - y);
					end
				end
				walk_x = x[7:0];
				walk_y = y[7:0];
				walk_delta = delta[9:0];
				res.read_data = 8'h00;
				res.was_read = 1'b0;
			end
			awaited.push_back(res);
		endfunction

		function void check_result(logic [7:0] read_data, logic was_read);
			fb_result_t exp_res;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing awaited: data %02h was_read %0b",
						$realtime, read_data, was_read);
				return;
			end
			exp_res = awaited.pop_front();
			checked++;
			if (exp_res.was_read && exp_res.read_data != 8'h00)
				nonzero_reads++;
			if (read_data !== exp_res.read_data || was_read !== exp_res.was_read) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d: expected data %02h was_read %0b, got %02h %0b",
						$realtime, checked, exp_res.read_data, exp_res.was_read,
						read_data, was_read);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	circle_scoreboard sb;
	bit idle_on = 1'b1;
	int hold_left = 0;
	int stall_left = 0;
	int cycles = 0;
	int n_draws = 0;
	int n_large = 0;
	int n_black = 0;
	int n_reads = 0;
	int last_cx = 64;
	int last_cy = 32;
	int last_r = 10;

	filled_circle_rasterizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, sb.pending());
			$display("** filled_circle_rasterizer: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 5);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic op, input logic [6:0] cx, input logic [5:0] cy,
		input logic [6:0] radius, input logic color, input logic [9:0] addr);
		logic [31:0] data;
		data = {1'b0, addr, color, radius, cy, cx};
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(op, data);
		if (op == OP_READ) begin
			n_reads++;
		end else begin
			n_draws++;
			if (radius > 7'd100)
				n_large++;
			if (color == PEN_CLEAR)
				n_black++;
			last_cx = int'(cx);
			last_cy = int'(cy);
			last_r = int'(radius);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() > 0);
	endtask

	initial begin
		int pick, reach, col, row;
		logic [6:0] radius;
		logic [9:0] addr;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_DRAW;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd1023);
		send_item(OP_DRAW, 7'd0, 6'd0, 7'd0, PEN_SET, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd0);
		send_item(OP_DRAW, 7'd127, 6'd63, 7'd0, PEN_SET, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd1023);
		send_item(OP_DRAW, 7'd127, 6'd0, 7'd6, PEN_SET, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd127);
		send_item(OP_DRAW, 7'd0, 6'd63, 7'd9, PEN_SET, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd896);
		send_item(OP_DRAW, 7'd0, 6'd63, 7'd4, PEN_CLEAR, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd896);
		send_item(OP_DRAW, 7'd64, 6'd32, 7'd127, PEN_SET, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd517);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd0);
		send_item(OP_DRAW, 7'd0, 6'd0, 7'd127, PEN_CLEAR, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd1023);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd512);
		send_item(OP_DRAW, 7'd100, 6'd20, 7'd40, PEN_SET, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd356);
		send_item(OP_DRAW, 7'd50, 6'd40, 7'd1, PEN_CLEAR, 10'd0);
		send_item(OP_READ, 7'd0, 6'd0, 7'd0, PEN_CLEAR, 10'd690);
		send_item(OP_DRAW, 7'd10, 6'd10, 7'd2, PEN_SET, 10'd1023);
		send_item(OP_READ, 7'd127, 6'd63, 7'd127, PEN_SET, 10'd138);
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = (i < RANDOM_ITEMS - 50) && ((i / 40) % 3 != 2);
			if (i == 90)
				hold_left = 300;
			if (i == 170)
				drain_results();
			if ($urandom_range(0, 1) == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 65)
					radius = 7'($urandom_range(0, 12));
				else if (pick < 92)
					radius = 7'($urandom_range(13, 40));
				else if (pick < 96)
					radius = 7'($urandom_range(41, 99));
				else
					radius = 7'($urandom_range(100, 127));
				send_item(OP_DRAW, 7'($urandom), 6'($urandom), radius,
					logic'($urandom_range(0, 2) != 0), 10'($urandom));
			end else begin
				addr = 10'($urandom);
				if ($urandom_range(0, 1) == 0) begin
					reach = (last_r < 20) ? last_r + 1 : 20;
					col = last_cx + $urandom_range(0, 2 * reach) - reach;
					row = last_cy + $urandom_range(0, 2 * reach) - reach;
					if (col >= 0 && col < FB_W && row >= 0 && row < FB_H)
						addr = 10'((row / ROWS_IN_PAGE) * FB_W + col);
				end
				send_item(OP_READ, 7'($urandom), 6'($urandom), 7'($urandom),
					logic'($urandom), addr);
			end
		end
		drain_results();
		repeat (40) @(posedge clk);

		$display("Covered %0d circle draws (%0d with radius above 100, %0d black) and %0d reads.",
			n_draws, n_large, n_black, n_reads);
		$display("Checked %0d results, %0d reads returned nonzero bytes, %0d mismatches.",
			sb.checked, sb.nonzero_reads, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** filled_circle_rasterizer: PASSED **");
		else
			$display("** filled_circle_rasterizer: FAILED **");
		$finish;
	end

endmodule
